@@ hdl/assert_macros.svh @@
// Assertion helpers for the files that check their own logic.
// Every check samples on the rising edge of clk and is off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every checked edge.
`define LWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define LWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_pkg
// Shared constants, control word layout and status types of the line editor.
// ----------------------------------------------------------------------------
package lwe_pkg;

  localparam int LINE_WIDTH = 40;
  localparam int LEN_W      = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W     = $clog2(LINE_WIDTH);
  localparam int CHAR_W     = 8;
  localparam int STORE_W    = 7;
  localparam int KIND_W     = 3;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int TDATA_W    = 16;
  localparam int PC_W       = 5;

  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO    = 3'd0,
    KIND_RUBOUT  = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_BELL    = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERASE  = 2'd0,
    CFG_KILL   = 2'd1,
    CFG_WERASE = 2'd2,
    CFG_EOF    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_LEN_ZERO, C_LEN_NZ, C_P_ZERO, C_SPACE, C_NOT_SPACE, C_P_EQ_Q
  } cond_t;

  typedef enum logic [2:0] {
    CNT_NONE, CNT_ONE, CNT_LEN, CNT_LEN_MINUS_P, CNT_Q_MINUS_P
  } cnt_sel_t;

  typedef enum logic [1:0] {
    CHR_ZERO, CHR_IN, CHR_RDATA
  } chr_sel_t;

  typedef enum logic [2:0] {
    LEN_HOLD, LEN_DEC, LEN_ZERO, LEN_SET_P, LEN_APPEND
  } len_op_t;

  typedef enum logic [1:0] {
    P_HOLD, P_LOAD_LEN, P_DEC, P_INC
  } p_op_t;

  typedef enum logic {
    RA_P_MINUS_1, RA_P
  } raddr_sel_t;

  typedef struct packed {
    logic              fetch;
    logic              emit;
    kind_t             kind;
    cnt_sel_t          cnt;
    chr_sel_t          chr;
    logic              last;
    len_op_t           len_op;
    p_op_t             p_op;
    logic              q_load;
    raddr_sel_t        raddr;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] q;
    logic             rd_space;
    logic             out_free;
  } status_t;

  // Program layout.
  localparam logic [PC_W-1:0] ST_FETCH     = 5'd0;
  localparam logic [PC_W-1:0] ST_ERASE     = 5'd1;
  localparam logic [PC_W-1:0] ST_ERASE_OUT = 5'd2;
  localparam logic [PC_W-1:0] ST_KILL      = 5'd3;
  localparam logic [PC_W-1:0] ST_KILL_OUT  = 5'd4;
  localparam logic [PC_W-1:0] ST_WERASE    = 5'd5;
  localparam logic [PC_W-1:0] ST_WA_RD     = 5'd6;
  localparam logic [PC_W-1:0] ST_WA_TEST   = 5'd7;
  localparam logic [PC_W-1:0] ST_WA_DEC    = 5'd8;
  localparam logic [PC_W-1:0] ST_WB_RD     = 5'd9;
  localparam logic [PC_W-1:0] ST_WB_TEST   = 5'd10;
  localparam logic [PC_W-1:0] ST_WB_DEC    = 5'd11;
  localparam logic [PC_W-1:0] ST_WE_DONE   = 5'd12;
  localparam logic [PC_W-1:0] ST_EOF       = 5'd13;
  localparam logic [PC_W-1:0] ST_EOF_OUT   = 5'd14;
  localparam logic [PC_W-1:0] ST_NL        = 5'd15;
  localparam logic [PC_W-1:0] ST_PRINT     = 5'd16;
  localparam logic [PC_W-1:0] ST_FULL_SP   = 5'd17;
  localparam logic [PC_W-1:0] ST_FULL_WORD = 5'd18;
  localparam logic [PC_W-1:0] ST_FW_RD     = 5'd19;
  localparam logic [PC_W-1:0] ST_FW_TEST   = 5'd20;
  localparam logic [PC_W-1:0] ST_FW_DEC    = 5'd21;
  localparam logic [PC_W-1:0] ST_FW_CUT    = 5'd22;
  localparam logic [PC_W-1:0] ST_FW_RUB    = 5'd23;
  localparam logic [PC_W-1:0] ST_FW_NL     = 5'd24;
  localparam logic [PC_W-1:0] ST_REPLAY    = 5'd25;
  localparam logic [PC_W-1:0] ST_REPLAY_RD = 5'd26;
  localparam logic [PC_W-1:0] ST_REPLAY_WR = 5'd27;
  localparam logic [PC_W-1:0] ST_BELL      = 5'd28;

  localparam ucode_t UC_NOP = '{
    fetch:  1'b0,
    emit:   1'b0,
    kind:   KIND_ECHO,
    cnt:    CNT_NONE,
    chr:    CHR_ZERO,
    last:   1'b0,
    len_op: LEN_HOLD,
    p_op:   P_HOLD,
    q_load: 1'b0,
    raddr:  RA_P_MINUS_1,
    cond:   C_NEVER,
    target: ST_FETCH
  };

endpackage

@@ hdl/lwe_ucode_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_ucode_rom
// Control store: one control word for each program step of the line editor.
// ----------------------------------------------------------------------------
module lwe_ucode_rom import lwe_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output ucode_t          word
);

  always_comb begin
    word = UC_NOP;
    case (pc)
      ST_FETCH: begin
        word.fetch = 1'b1;
      end
      ST_ERASE: begin
        word.cond   = C_LEN_ZERO;
        word.target = ST_FETCH;
      end
      ST_ERASE_OUT: begin
        word.emit   = 1'b1;
        word.kind   = KIND_RUBOUT;
        word.cnt    = CNT_ONE;
        word.last   = 1'b1;
        word.len_op = LEN_DEC;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_KILL: begin
        word.cond   = C_LEN_ZERO;
        word.target = ST_FETCH;
      end
      ST_KILL_OUT: begin
        word.emit   = 1'b1;
        word.kind   = KIND_RUBOUT;
        word.cnt    = CNT_LEN;
        word.last   = 1'b1;
        word.len_op = LEN_ZERO;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_WERASE: begin
        word.p_op   = P_LOAD_LEN;
        word.cond   = C_LEN_ZERO;
        word.target = ST_FETCH;
      end
      // First pass walks back over the word, second over the spaces before it.
      ST_WA_RD: begin
        word.cond   = C_P_ZERO;
        word.target = ST_WE_DONE;
      end
      ST_WA_TEST: begin
        word.cond   = C_SPACE;
        word.target = ST_WB_DEC;
      end
      ST_WA_DEC: begin
        word.p_op   = P_DEC;
        word.cond   = C_ALWAYS;
        word.target = ST_WA_RD;
      end
      ST_WB_RD: begin
        word.cond   = C_P_ZERO;
        word.target = ST_WE_DONE;
      end
      ST_WB_TEST: begin
        word.cond   = C_NOT_SPACE;
        word.target = ST_WE_DONE;
      end
      ST_WB_DEC: begin
        word.p_op   = P_DEC;
        word.cond   = C_ALWAYS;
        word.target = ST_WB_RD;
      end
      ST_WE_DONE: begin
        word.emit   = 1'b1;
        word.kind   = KIND_RUBOUT;
        word.cnt    = CNT_LEN_MINUS_P;
        word.last   = 1'b1;
        word.len_op = LEN_SET_P;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_EOF: begin
        word.cond   = C_LEN_NZ;
        word.target = ST_FETCH;
      end
      ST_EOF_OUT: begin
        word.emit   = 1'b1;
        word.kind   = KIND_END;
        word.last   = 1'b1;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_NL: begin
        word.emit   = 1'b1;
        word.kind   = KIND_NEWLINE;
        word.last   = 1'b1;
        word.len_op = LEN_ZERO;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_PRINT: begin
        word.emit   = 1'b1;
        word.kind   = KIND_ECHO;
        word.chr    = CHR_IN;
        word.last   = 1'b1;
        word.len_op = LEN_APPEND;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      ST_FULL_SP: begin
        word.emit   = 1'b1;
        word.kind   = KIND_NEWLINE;
        word.len_op = LEN_ZERO;
        word.cond   = C_ALWAYS;
        word.target = ST_PRINT;
      end
      ST_FULL_WORD: begin
        word.p_op   = P_LOAD_LEN;
        word.q_load = 1'b1;
      end
      // A full line with no space just breaks before the new character.
      ST_FW_RD: begin
        word.cond   = C_P_ZERO;
        word.target = ST_FULL_SP;
      end
      ST_FW_TEST: begin
        word.cond   = C_SPACE;
        word.target = ST_FW_CUT;
      end
      ST_FW_DEC: begin
        word.p_op   = P_DEC;
        word.cond   = C_ALWAYS;
        word.target = ST_FW_RD;
      end
      ST_FW_CUT: begin
        word.cond   = C_P_EQ_Q;
        word.target = ST_FW_NL;
      end
      ST_FW_RUB: begin
        word.emit = 1'b1;
        word.kind = KIND_RUBOUT;
        word.cnt  = CNT_Q_MINUS_P;
      end
      ST_FW_NL: begin
        word.emit   = 1'b1;
        word.kind   = KIND_NEWLINE;
        word.len_op = LEN_ZERO;
      end
      ST_REPLAY: begin
        word.cond   = C_P_EQ_Q;
        word.target = ST_PRINT;
      end
      ST_REPLAY_RD: begin
        word.raddr = RA_P;
      end
      ST_REPLAY_WR: begin
        word.emit   = 1'b1;
        word.kind   = KIND_ECHO;
        word.chr    = CHR_RDATA;
        word.len_op = LEN_APPEND;
        word.p_op   = P_INC;
        word.raddr  = RA_P;
        word.cond   = C_ALWAYS;
        word.target = ST_REPLAY;
      end
      ST_BELL: begin
        word.emit   = 1'b1;
        word.kind   = KIND_BELL;
        word.last   = 1'b1;
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
      default: begin
        word.cond   = C_ALWAYS;
        word.target = ST_FETCH;
      end
    endcase
  end

endmodule

@@ hdl/lwe_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_line_ram
// Line buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwe_line_ram import lwe_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [STORE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [STORE_W-1:0] rdata
);

  logic [STORE_W-1:0] mem [LINE_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lwe_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwe_datapath
// Line length, scan pointers, line buffer and the result output register.
// ----------------------------------------------------------------------------
module lwe_datapath import lwe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ucode_t             word,
  input  logic               go,
  input  logic [CHAR_W-1:0]  cur_char,
  input  logic               out_ready,
  output status_t            st,
  output logic               out_valid,
  output kind_t              out_kind,
  output logic [CHAR_W-1:0]  out_echo,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_last
);

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   p;
  logic [LEN_W-1:0]   q;
  logic [LEN_W-1:0]   p_dec;
  logic [ADDR_W-1:0]  raddr;
  logic [STORE_W-1:0] rdata;
  logic [CHAR_W-1:0]  chr_val;
  logic [LEN_W-1:0]   cnt_val;
  logic               we;

  assign p_dec = p - 1'b1;

  always_comb begin
    case (word.raddr)
      RA_P:    raddr = p[ADDR_W-1:0];
      default: raddr = p_dec[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (word.chr)
      CHR_IN:    chr_val = cur_char;
      CHR_RDATA: chr_val = {1'b0, rdata};
      default:   chr_val = '0;
    endcase
  end

  always_comb begin
    case (word.cnt)
      CNT_ONE:         cnt_val = LEN_W'(1);
      CNT_LEN:         cnt_val = len;
      CNT_LEN_MINUS_P: cnt_val = len - p;
      CNT_Q_MINUS_P:   cnt_val = q - p;
      default:         cnt_val = '0;
    endcase
  end

  assign we = go && (word.len_op == LEN_APPEND);

  lwe_line_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (len[ADDR_W-1:0]),
    .wdata (chr_val[STORE_W-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (go) begin
      case (word.len_op)
        LEN_DEC:    len <= len - 1'b1;
        LEN_ZERO:   len <= '0;
        LEN_SET_P:  len <= p;
        LEN_APPEND: len <= len + 1'b1;
        default:    len <= len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      case (word.p_op)
        P_LOAD_LEN: p <= len;
        P_DEC:      p <= p_dec;
        P_INC:      p <= p + 1'b1;
        default:    p <= p;
      endcase
      if (word.q_load) begin
        q <= len;
      end
    end
  end

  // The output register holds one result; the sequencer stalls at a step that emits while it is full and not taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && word.emit) begin
      out_valid <= 1'b1;
      out_kind  <= word.kind;
      out_echo  <= chr_val;
      out_count <= COUNT_W'(cnt_val);
      out_last  <= word.last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign st.len      = len;
  assign st.p        = p;
  assign st.q        = q;
  assign st.rd_space = (rdata == CH_SPACE[STORE_W-1:0]);
  assign st.out_free = !out_valid || out_ready;

endmodule

@@ hdl/line_editor_with_word_wrap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_with_word_wrap
// Terminal line editor with word wrap, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Typed bytes arrive on the s_axis channel, one byte per transaction. Each
// byte produces zero or more echo commands on the m_axis channel; tuser
// carries the command kind and tlast marks the final command caused by a
// byte. The cfg port rewrites the erase, kill, word-erase and eof codes;
// write it only while the block is idle.
// Reset loads the default codes, empties the line and clears the output
// register; the line buffer itself is not cleared and needs no sweep.
// Only one byte is worked on at a time: s_axis_tready is high in the fetch
// step alone. After its fetch, a byte runs through its program steps. Word
// erase and wrap walk the line buffer through its single read port, with a
// read, a test and a step back for each character scanned, and the wrap
// replay checks, reads and writes back each moved character in turn.
// The first command of a byte is visible in the cycle after its step runs.
// While the receiver stalls, the output register holds its command and the
// sequencer waits at the next step that has a command to give.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_editor_with_word_wrap import lwe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] in_char
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // [7:0] echo_char, [13:8] rubout_count,
                                               // rest zero
  output logic [KIND_W-1:0]    m_axis_tuser,   // [2:0] kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data
);

  logic [CHAR_W-1:0]  erase_char;
  logic [CHAR_W-1:0]  kill_char;
  logic [CHAR_W-1:0]  word_erase_char;
  logic [CHAR_W-1:0]  eof_char;
  logic [CHAR_W-1:0]  cur_char;
  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  logic [PC_W-1:0]    entry;
  ucode_t             word;
  status_t            st;
  logic               cond_true;
  logic               stall;
  logic               go;
  logic               line_full;
  kind_t              out_kind;
  logic [CHAR_W-1:0]  out_echo;
  logic [COUNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char      <= 8'd127;
      kill_char       <= 8'd21;
      word_erase_char <= 8'd23;
      eof_char        <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ERASE:  erase_char      <= cfg_data;
        CFG_KILL:   kill_char       <= cfg_data;
        CFG_WERASE: word_erase_char <= cfg_data;
        CFG_EOF:    eof_char        <= cfg_data;
        default:    erase_char      <= erase_char;
      endcase
    end
  end

  lwe_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  // Classify the incoming byte; the earlier check wins on equal codes.
  assign line_full = (st.len >= LEN_W'(LINE_WIDTH));

  always_comb begin
    if (s_axis_tdata == erase_char) begin
      entry = ST_ERASE;
    end else if (s_axis_tdata == kill_char) begin
      entry = ST_KILL;
    end else if (s_axis_tdata == word_erase_char) begin
      entry = ST_WERASE;
    end else if (s_axis_tdata == eof_char) begin
      entry = ST_EOF;
    end else if (s_axis_tdata == CH_NEWLINE) begin
      entry = ST_NL;
    end else if (s_axis_tdata inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
      if (!line_full) begin
        entry = ST_PRINT;
      end else if (s_axis_tdata == CH_SPACE) begin
        entry = ST_FULL_SP;
      end else begin
        entry = ST_FULL_WORD;
      end
    end else begin
      entry = ST_BELL;
    end
  end

  always_comb begin
    case (word.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_LEN_ZERO:  cond_true = (st.len == '0);
      C_LEN_NZ:    cond_true = (st.len != '0);
      C_P_ZERO:    cond_true = (st.p == '0);
      C_SPACE:     cond_true = st.rd_space;
      C_NOT_SPACE: cond_true = !st.rd_space;
      C_P_EQ_Q:    cond_true = (st.p == st.q);
      default:     cond_true = 1'b0;
    endcase
  end

  assign s_axis_tready = word.fetch;
  assign stall = (word.fetch && !s_axis_tvalid) || (word.emit && !st.out_free);
  assign go    = !stall;

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (word.fetch) begin
      pc_next = entry;
    end else if (cond_true) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cur_char <= s_axis_tdata;
    end
  end

  lwe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .go        (go),
    .cur_char  (cur_char),
    .out_ready (m_axis_tready),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_kind  (out_kind),
    .out_echo  (out_echo),
    .out_count (out_count),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_W - CHAR_W - COUNT_W)'(0), out_count, out_echo};
  assign m_axis_tuser = out_kind;

  `LWE_ASSERT(a_len_bound, st.len <= LEN_W'(LINE_WIDTH), "line length beyond line width")
  `LWE_ASSERT_NEXT(a_one_byte, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second byte taken")
  `LWE_ASSERT(a_replay_range, (pc != ST_REPLAY_RD) || (st.p < st.q), "replay beyond old line end")
  `LWE_ASSERT(a_rubout_count, !(m_axis_tvalid && out_kind == KIND_RUBOUT) || (out_count != '0), "empty rub-out")

endmodule
